### hdl/pwf_pkg.sv
// pwf_pkg: shared types and constants for the pulse window finder.
// No dependencies; imported by pulse_window_finder.
`default_nettype none

package pwf_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths of the register and the result beat
    localparam int RUN_W   = 4;
    localparam int IDX_O_W = 10;
    localparam int SUM_W   = 22;

    localparam logic [RUN_W-1:0] RUN_RESET = RUN_W'(3);
    localparam logic [RUN_W-1:0] RUN_MAX   = '1;

    typedef enum logic [1:0] {
        PH_SEARCH = 2'd0,
        PH_WINDOW = 2'd1,
        PH_ENDED  = 2'd2
    } t_phase;

endpackage

`default_nettype wire

### hdl/pulse_window_finder.sv
// pulse_window_finder: leading-edge and pulse-window search over one waveform; uses pwf_pkg.
// The result beat is registered: it appears in the cycle after the sample beat flagged last is taken.
// Throughput: one sample per cycle while no result waits; the only loop is the registered state update.
// A result waiting in the output register holds off every sample beat until it is taken.
// Reset (synchronous, active low): run length 3, all per-waveform state cleared.
`default_nettype none

module pulse_window_finder #(
    parameter int MAX_SAMPLES = pwf_pkg::MAX_SAMPLES_DEF,
    parameter int SAMPLE_BITS = pwf_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // configuration
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [pwf_pkg::RUN_W-1:0]   i_cfg_wr_data,
    // sample channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]      i_sample,
    input  wire logic                        i_last,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic                             o_edge_found,
    output logic                             o_end_found,
    output logic [pwf_pkg::IDX_O_W-1:0]      o_start_index,
    output logic [pwf_pkg::IDX_O_W-1:0]      o_end_index,
    output logic [pwf_pkg::SUM_W-1:0]        o_window_sum
);
    import pwf_pkg::*;

    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int MW = SAMPLE_BITS + 3;
    localparam logic [IW-1:0] IDX_LAST = IW'(MAX_SAMPLES - 1);

    logic [RUN_W-1:0]       r_needed_cfg;
    logic [IW-1:0]          r_idx,       n_idx;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic [RUN_W-1:0]       r_run,       n_run;
    t_phase                 r_phase,     n_phase;
    logic [IW-1:0]          r_start_pos, n_start_pos;
    logic [SAMPLE_BITS-1:0] r_lvl,       n_lvl;
    logic [IW-1:0]          r_end_pos,   n_end_pos;
    logic [SUM_W-1:0]       r_sum,       n_sum;

    logic                   r_out_valid;
    logic                   r_edge, r_end;
    logic [IDX_O_W-1:0]     r_start_o, r_end_o;
    logic [SUM_W-1:0]       r_sum_o;

    logic                   accept;
    logic [RUN_W-1:0]       needed;
    logic                   testing, rise, start, in_window, ended_now;
    logic [MW-1:0]          lhs, rhs;
    logic [RUN_W-1:0]       run_inc;
    logic [SAMPLE_BITS-1:0] base;
    logic [SUM_W:0]         sum_raw;
    logic [IW+IDX_O_W-1:0]  start_ext, end_ext;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign needed = (r_needed_cfg == '0) ? RUN_W'(1) : r_needed_cfg;

    // 5*(next-cur) > cur  <=>  5*next > 6*cur, all unsigned
    assign lhs  = MW'(i_sample) * MW'(5);
    assign rhs  = MW'(r_prev) * MW'(6);
    assign rise = lhs > rhs;

    assign testing   = (r_phase == PH_SEARCH) && (r_idx >= IW'(2));
    assign run_inc   = (r_run == RUN_MAX) ? RUN_MAX : r_run + RUN_W'(1);
    assign start     = testing && rise && (run_inc >= needed);
    assign in_window = start || (r_phase == PH_WINDOW);
    assign n_lvl     = start ? r_prev : r_lvl;
    assign ended_now = in_window && (i_sample < n_lvl);

    // Next phase
    always_comb begin
        priority if (ended_now) begin
            n_phase = PH_ENDED;
        end else if (in_window) begin
            n_phase = PH_WINDOW;
        end else begin
            n_phase = r_phase;
        end
    end

    // Datapath next values
    always_comb begin
        n_run = r_run;
        if (testing) begin
            n_run = rise ? run_inc : '0;
        end
        base    = start ? r_prev : '0;
        sum_raw = (start ? '0 : {1'b0, r_sum}) + (SUM_W+1)'(base) + (SUM_W+1)'(i_sample);
        n_sum   = r_sum;
        if (in_window) begin
            n_sum = sum_raw[SUM_W] ? '1 : sum_raw[SUM_W-1:0];
        end
        n_start_pos = start ? r_idx - IW'(1) : r_start_pos;
        n_end_pos   = ended_now ? r_idx : r_end_pos;
        n_idx       = (r_idx == IDX_LAST) ? r_idx : r_idx + IW'(1);
    end

    assign start_ext = {{IDX_O_W{1'b0}}, n_start_pos};
    assign end_ext   = {{IDX_O_W{1'b0}}, n_end_pos};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needed_cfg <= RUN_RESET;
            r_idx        <= '0;
            r_prev       <= '0;
            r_run        <= '0;
            r_phase      <= PH_SEARCH;
            r_start_pos  <= '0;
            r_lvl        <= '0;
            r_end_pos    <= '0;
            r_sum        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_needed_cfg <= i_cfg_wr_data;
            end
            if (o_in_ready) begin
                r_out_valid <= accept && i_last;
            end
            if (accept) begin
                if (i_last) begin
                    // waveform closed: clear for the next one
                    r_idx       <= '0;
                    r_prev      <= '0;
                    r_run       <= '0;
                    r_phase     <= PH_SEARCH;
                    r_start_pos <= '0;
                    r_lvl       <= '0;
                    r_end_pos   <= '0;
                    r_sum       <= '0;
                end else begin
                    r_idx       <= n_idx;
                    r_prev      <= i_sample;
                    r_run       <= n_run;
                    r_phase     <= n_phase;
                    r_start_pos <= n_start_pos;
                    r_lvl       <= n_lvl;
                    r_end_pos   <= n_end_pos;
                    r_sum       <= n_sum;
                end
            end
        end
    end

    // Result beat payload
    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_edge    <= (n_phase != PH_SEARCH);
            r_end     <= (n_phase == PH_ENDED);
            r_start_o <= (n_phase != PH_SEARCH) ? start_ext[IDX_O_W-1:0] : '0;
            r_end_o   <= (n_phase == PH_ENDED) ? end_ext[IDX_O_W-1:0] : '0;
            r_sum_o   <= (n_phase != PH_SEARCH) ? n_sum : '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_edge_found  = r_edge;
    assign o_end_found   = r_end;
    assign o_start_index = r_start_o;
    assign o_end_index   = r_end_o;
    assign o_window_sum  = r_sum_o;

    // Checks
    a_search_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_SEARCH) |-> (r_sum == '0 && r_start_pos == '0))
        else $error("window state set while still searching");

    a_end_pos_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_ENDED) |-> (r_end_pos == '0))
        else $error("end position set before window ended");

    a_end_needs_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_found) |-> o_edge_found)
        else $error("end reported without an edge");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_last) |=> (r_idx == '0 && r_phase == PH_SEARCH && r_run == '0))
        else $error("waveform state not cleared after last beat");

endmodule

`default_nettype wire

### tb/tb_pulse_window_finder.sv
// tb_pulse_window_finder: self-checking bench for the pulse window finder.
// Directed, long and random waveforms go in; each report beat is checked against
// an in-bench predictor. Depends on pwf_pkg and pulse_window_finder.
`default_nettype none

module tb_pulse_window_finder;
    import pwf_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE       = 4;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_BEATS = 200;
    localparam int MAX_INDEX    = MAX_SAMPLES_DEF - 1;
    localparam int SUM_MAX      = (1 << SUM_W) - 1;

    typedef struct packed {
        logic               edge_found;
        logic               end_found;
        logic [IDX_O_W-1:0] start_index;
        logic [IDX_O_W-1:0] end_index;
        logic [SUM_W-1:0]   window_sum;
    } t_pulse_report;

    // Tracks one waveform at a time and queues the report each last beat causes.
    class t_pulse_window_board;
        logic [RUN_W-1:0]   run_needed;
        logic [9:0]         sample_index;
        logic [11:0]        prev_sample;
        logic [RUN_W-1:0]   rise_run;
        t_phase             phase;
        logic [9:0]         start_pos;
        logic [11:0]        start_level;
        logic [9:0]         end_pos;
        int unsigned        running_sum;
        t_pulse_report      expected_reports[$];
        int                 failures;
        int                 reports_checked;

        function new();
            run_needed      = RUN_RESET;
            failures        = 0;
            reports_checked = 0;
            clear_waveform();
        endfunction

        function void clear_waveform();
            sample_index = '0;
            prev_sample  = '0;
            rise_run     = '0;
            phase        = PH_SEARCH;
            start_pos    = '0;
            start_level  = '0;
            end_pos      = '0;
            running_sum  = 0;
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction

        function void note_sample(logic [11:0] s, logic is_last);
            int cur;
            int nxt;
            logic [RUN_W-1:0] needed;
            t_pulse_report rep;
            needed = (run_needed == 0) ? RUN_W'(1) : run_needed;
            // first pair tested is (index 1, index 2)
            if (phase == PH_SEARCH && sample_index >= 2) begin
                cur = prev_sample;
                nxt = s;
                if (5 * (nxt - cur) > cur) begin
                    if (rise_run != RUN_MAX)
                        rise_run++;
                    if (rise_run >= needed) begin
                        phase       = PH_WINDOW;
                        start_pos   = sample_index - 10'd1;
                        start_level = prev_sample;
                        running_sum = prev_sample;
                    end
                end else begin
                    rise_run = '0;
                end
            end
            if (phase == PH_WINDOW) begin
                running_sum += s;
                if (running_sum > SUM_MAX)
                    running_sum = SUM_MAX;
                if (s < start_level) begin
                    end_pos = sample_index;
                    phase   = PH_ENDED;
                end
            end
            prev_sample = s;
            if (sample_index != MAX_INDEX)
                sample_index++;
            if (is_last) begin
                rep.edge_found  = (phase != PH_SEARCH);
                rep.end_found   = (phase == PH_ENDED);
                rep.start_index = (phase != PH_SEARCH) ? start_pos : '0;
                rep.end_index   = (phase == PH_ENDED) ? end_pos : '0;
                rep.window_sum  = (phase != PH_SEARCH) ? running_sum[SUM_W-1:0] : '0;
                expected_reports.push_back(rep);
                clear_waveform();
            end
        endfunction

        function void check_report(t_pulse_report got);
            t_pulse_report exp_rep;
            if (expected_reports.size() == 0) begin
                $error("report beat arrived with no report expected");
                failures++;
                return;
            end
            exp_rep = expected_reports.pop_front();
            reports_checked++;
            if (got.edge_found !== exp_rep.edge_found) begin
                $error("edge_found: expected %0d, got %0d", exp_rep.edge_found, got.edge_found);
                failures++;
            end
            if (got.end_found !== exp_rep.end_found) begin
                $error("end_found: expected %0d, got %0d", exp_rep.end_found, got.end_found);
                failures++;
            end
            if (got.start_index !== exp_rep.start_index) begin
                $error("start_index: expected %0d, got %0d",
                       exp_rep.start_index, got.start_index);
                failures++;
            end
            if (got.end_index !== exp_rep.end_index) begin
                $error("end_index: expected %0d, got %0d", exp_rep.end_index, got.end_index);
                failures++;
            end
            if (got.window_sum !== exp_rep.window_sum) begin
                $error("window_sum: expected %0d, got %0d",
                       exp_rep.window_sum, got.window_sum);
                failures++;
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [RUN_W-1:0]   cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [11:0]        sample_data = '0;
    logic               sample_last = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               edge_found;
    logic               end_found;
    logic [IDX_O_W-1:0] start_index;
    logic [IDX_O_W-1:0] end_index;
    logic [SUM_W-1:0]   window_sum;

    logic                 no_idle = 1'b0;
    logic                 hold_request = 1'b0;
    int                   cycle_count = 0;
    int                   beats_sent = 0;
    int                   waves_sent = 0;
    int                   settings_used = 0;
    logic [11:0]          wave[$];
    t_pulse_window_board  board = new();

    pulse_window_finder u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_sample      (sample_data),
        .i_last        (sample_last),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_edge_found  (edge_found),
        .o_end_found   (end_found),
        .o_start_index (start_index),
        .o_end_index   (end_index),
        .o_window_sum  (window_sum)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    function automatic logic [11:0] clamp12(int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'd4095;
        return v[11:0];
    endfunction

    // Report side: random stalls, plus a long hold when asked for.
    initial begin : report_sink
        int stall_left;
        int r;
        t_pulse_report got;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready) begin
                got.edge_found  = edge_found;
                got.end_found   = end_found;
                got.start_index = start_index;
                got.end_index   = end_index;
                got.window_sum  = window_sum;
                board.check_report(got);
            end
            if (hold_request) begin
                hold_request <= 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (no_idle) begin
                out_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    out_ready <= 1'b1;
                end else begin
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(3, 24);
                    out_ready <= 1'b0;
                end
            end
        end
    end

    // Valid stays high across back-to-back beats; lowered only for a gap.
    task automatic send_beat(input logic [11:0] s, input logic is_last);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        sample_data <= s;
        sample_last <= is_last;
        do @(posedge clk); while (!in_ready);
        board.note_sample(s, is_last);
        beats_sent++;
    endtask

    task automatic send_wave();
        foreach (wave[i])
            send_beat(wave[i], i == wave.size() - 1);
        waves_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_run_needed(input logic [RUN_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.run_needed = v;
        settings_used++;
    endtask

    // Baseline, geometric rise (some steps right at the 20 percent line),
    // plateau, decay that may or may not drop below the start level, tail.
    task automatic make_pulse_wave();
        int base;
        int v;
        int n;
        wave.delete();
        base = $urandom_range(0, 400);
        n = $urandom_range(1, 6);
        repeat (n) wave.push_back(clamp12(base + int'($urandom_range(0, 20)) - 10));
        v = base;
        n = $urandom_range(1, 17);
        repeat (n) begin
            case ($urandom_range(0, 7))
                0: v = v + v / 5;
                1: v = v + v / 5 + 1;
                default: v = v + v / 4 + 1 + int'($urandom_range(0, v / 2 + 8));
            endcase
            if (v > 4095)
                v = 4095;
            wave.push_back(clamp12(v));
        end
        n = $urandom_range(0, 6);
        repeat (n) wave.push_back(clamp12(v - int'($urandom_range(0, v / 8 + 1))));
        n = $urandom_range(0, 10);
        repeat (n) begin
            v = v - int'($urandom_range(1, v / 3 + 2));
            if (v < 0)
                v = 0;
            wave.push_back(clamp12(v));
        end
        n = $urandom_range(0, 4);
        repeat (n) wave.push_back(clamp12(base + int'($urandom_range(0, 20)) - 10));
    endtask

    task automatic make_noise_wave(input int max_len);
        int n;
        wave.delete();
        n = $urandom_range(1, max_len);
        repeat (n) begin
            case ($urandom_range(0, 7))
                0: wave.push_back(12'd0);
                1: wave.push_back(12'd4095);
                default: wave.push_back(12'($urandom_range(0, 4095)));
            endcase
        end
    endtask

    initial begin : stimulus
        int random_beats;
        int seg;
        int kind;
        int drain;
        logic [RUN_W-1:0] run_val;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed waveforms at the reset run length
        wave = '{12'd4095};
        send_wave();
        wave = '{12'd0, 12'd4095};
        send_wave();
        // zero current sample counts as a rise; no end found
        wave = '{12'd0, 12'd0, 12'd1, 12'd2, 12'd4, 12'd3};
        send_wave();
        // 100 -> 120 sits exactly on the threshold and is not a rise
        wave = '{12'd0, 12'd100, 12'd120, 12'd145, 12'd175, 12'd211, 12'd100};
        send_wave();
        wave = '{12'd0, 12'd1000, 12'd1300, 12'd1700, 12'd2300, 12'd4095, 12'd4095, 12'd0};
        send_wave();

        // index saturation with a saturated sum and a late end
        wave = '{12'd0, 12'd1, 12'd2, 12'd4, 12'd8, 12'd16};
        repeat (1030) wave.push_back(12'd4095);
        wave.push_back(12'd0);
        send_wave();

        // long report stall while short waveforms keep coming, so input backs up
        wait_idle();
        hold_request <= 1'b1;
        no_idle <= 1'b1;
        repeat (20) begin
            make_noise_wave(2);
            send_wave();
        end
        no_idle <= 1'b0;
        wait_idle();

        random_beats = 0;
        seg = 0;
        while (random_beats < RANDOM_BEATS || seg < 11) begin
            if (seg % 5 == 0) begin
                case (seg / 5)
                    0: run_val = RUN_W'(1);
                    1: run_val = RUN_MAX;
                    2: run_val = '0;
                    default: run_val = RUN_W'($urandom_range(0, 15));
                endcase
                wait_idle();
                write_run_needed(run_val);
            end
            no_idle <= ($urandom_range(0, 5) == 0);
            kind = $urandom_range(0, 9);
            if (kind < 7)
                make_pulse_wave();
            else if (kind == 7)
                make_noise_wave(40);
            else
                make_noise_wave(2);
            send_wave();
            random_beats += wave.size();
            seg++;
        end

        in_valid <= 1'b0;
        drain = 0;
        while (drain < DRAIN_LIMIT && board.pending() != 0) begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE) @(posedge clk);
        if (board.pending() != 0) begin
            $error("%0d expected reports never arrived", board.pending());
            board.failures++;
        end

        $display("Covered %0d sample beats in %0d waveforms, %0d reports checked.",
                 beats_sent, waves_sent, board.reports_checked);
        $display("Run lengths written %0d times, incl. 0, 1 and 15; index and sum saturation.",
                 settings_used);
        if (board.failures == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
